### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the angle/bias filter.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/kabf_pkg.sv
// Package for the angle/bias Kalman filter: widths, types, operand map,
// micro-program and fixed-point helpers. No dependencies.
package kabf_pkg;

    localparam int FRAC_BITS = 20;
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 64;
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int MEM_AW    = 6;
    localparam int MEM_DEPTH = 1 << MEM_AW;
    localparam int OPA_W     = 7;
    localparam int PC_W      = 8;
    localparam int PROG_LEN  = 1 << PC_W;
    localparam int PADDR_W   = 5;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [ACC_W-1:0]  t_acc;

    localparam t_data ONE_Q   = t_data'(longint'(1) << FRAC_BITS);
    localparam t_acc  HALF_Q  = t_acc'(longint'(1) << (FRAC_BITS - 1));
    localparam t_acc  SAT_MAX = t_acc'(64'sd2147483647);
    localparam t_acc  SAT_MIN = t_acc'(-64'sd2147483648);
    localparam longint BIAS_RAW = longint'(1000) * (longint'(1) << FRAC_BITS);
    localparam t_data BIAS_VAR_RST = (BIAS_RAW > longint'(2147483647)) ?
                                     t_data'(32'h7fff_ffff) : t_data'(BIAS_RAW);

    // Working store map (memory addresses)
    localparam int AD_X  = 0;   // state vector, 3
    localparam int AD_P  = 3;   // covariance, 9, row major
    localparam int AD_T  = 12;  // product scratch, 9
    localparam int AD_K  = 21;  // gain, 6
    localparam int AD_IV = 27;  // inverse of S, 4
    localparam int AD_S  = 31;  // S, 4
    localparam int AD_E  = 35;  // innovation, 2
    localparam int AD_A  = 37;  // I - K H, first two columns, 6
    // Operands outside the memory
    localparam int AD_TS   = 64;
    localparam int AD_GAIN = 65;
    localparam int AD_NA   = 66;
    localparam int AD_NC   = 67;
    localparam int AD_NV   = 68;
    localparam int AD_NB   = 69;
    localparam int AD_MNA  = 70;
    localparam int AD_MNV  = 71;
    localparam int AD_Y0   = 72;
    localparam int AD_Y1   = 73;
    localparam int AD_U0   = 74;
    localparam int AD_U1   = 75;
    localparam int AD_ONE  = 76;
    localparam int AD_ZERO = 77;

    typedef enum logic [3:0] {
        OP_END, OP_CLR, OP_LD, OP_ADD, OP_SUB, OP_MADD, OP_MSUB,
        OP_ST, OP_STDET, OP_BZ, OP_DIV, OP_DIVN, OP_OUT
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [OPA_W-1:0] a;
        logic [OPA_W-1:0] b;
        logic [PC_W-1:0]  d;
    } t_uop;

    typedef t_uop [PROG_LEN-1:0] t_prog;

    typedef enum logic [2:0] {
        ST_INIT, ST_IDLE, ST_READ, ST_MUL, ST_EXEC
    } t_state;

    typedef enum logic [2:0] {
        REG_TS, REG_GAIN, REG_NA, REG_NC, REG_NV, REG_NB, REG_MNA, REG_MNV
    } t_reg;

    typedef struct packed {
        logic [30:0] sample_period;
        logic [31:0] input_gain;
        logic [30:0] noise_angle;
        logic [31:0] noise_cross;
        logic [30:0] noise_velocity;
        logic [30:0] noise_bias;
        logic [30:0] meas_noise_angle;
        logic [30:0] meas_noise_velocity;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic              init_we;
        logic [MEM_AW-1:0] init_addr;
        logic              load;
        logic              rd;
        logic              mul;
        logic              exe;
        t_uop              uop;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic det_zero;
        logic div_done;
        logic out_free;
    } t_sts;

    function automatic t_data sat32(input t_acc v);
        if (v > SAT_MAX) begin
            return t_data'(32'h7fff_ffff);
        end else if (v < SAT_MIN) begin
            return t_data'(32'h8000_0000);
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic t_uop mk(input t_op op, input int a, input int b, input int d);
        t_uop u;
        u.op = op;
        u.a  = OPA_W'(a);
        u.b  = OPA_W'(b);
        u.d  = PC_W'(d);
        return u;
    endfunction

    // One filter step as a sequence of accumulator operations
    function automatic t_prog build_prog();
        t_prog p;
        int n;
        int bz;
        int i;
        int j;
        int k;
        for (i = 0; i < PROG_LEN; i++) p[i] = mk(OP_END, 0, 0, 0);
        n = 0;
        // S = H P H' + R
        p[n] = mk(OP_LD, AD_P + 0, 0, 0);     n++;
        p[n] = mk(OP_ADD, AD_MNA, 0, 0);      n++;
        p[n] = mk(OP_ST, 0, 0, AD_S + 0);     n++;
        p[n] = mk(OP_LD, AD_P + 4, 0, 0);     n++;
        p[n] = mk(OP_ADD, AD_MNV, 0, 0);      n++;
        p[n] = mk(OP_ST, 0, 0, AD_S + 3);     n++;
        // determinant
        p[n] = mk(OP_CLR, 0, 0, 0);                 n++;
        p[n] = mk(OP_MADD, AD_S + 0, AD_S + 3, 0);  n++;
        p[n] = mk(OP_MSUB, AD_P + 1, AD_P + 3, 0);  n++;
        p[n] = mk(OP_STDET, 0, 0, 0);               n++;
        bz = n;                                     n++;
        // inverse through the adjugate
        p[n] = mk(OP_DIV, AD_S + 3, 0, AD_IV + 0);  n++;
        p[n] = mk(OP_DIVN, AD_P + 1, 0, AD_IV + 1); n++;
        p[n] = mk(OP_DIVN, AD_P + 3, 0, AD_IV + 2); n++;
        p[n] = mk(OP_DIV, AD_S + 0, 0, AD_IV + 3);  n++;
        // gain
        for (i = 0; i < 3; i++) begin
            for (j = 0; j < 2; j++) begin
                p[n] = mk(OP_CLR, 0, 0, 0);                               n++;
                p[n] = mk(OP_MADD, AD_P + i * 3, AD_IV + j, 0);           n++;
                p[n] = mk(OP_MADD, AD_P + i * 3 + 1, AD_IV + 2 + j, 0);   n++;
                p[n] = mk(OP_ST, 0, 0, AD_K + i * 2 + j);                 n++;
            end
        end
        // innovation
        for (j = 0; j < 2; j++) begin
            p[n] = mk(OP_LD, AD_Y0 + j, 0, 0);  n++;
            p[n] = mk(OP_SUB, AD_X + j, 0, 0);  n++;
            p[n] = mk(OP_ST, 0, 0, AD_E + j);   n++;
        end
        // state update
        for (i = 0; i < 3; i++) begin
            p[n] = mk(OP_LD, AD_X + i, 0, 0);                  n++;
            p[n] = mk(OP_MADD, AD_K + i * 2, AD_E + 0, 0);     n++;
            p[n] = mk(OP_MADD, AD_K + i * 2 + 1, AD_E + 1, 0); n++;
            p[n] = mk(OP_ST, 0, 0, AD_X + i);                  n++;
        end
        // I - K H
        for (i = 0; i < 3; i++) begin
            for (k = 0; k < 2; k++) begin
                p[n] = mk(OP_LD, (i == k) ? AD_ONE : AD_ZERO, 0, 0); n++;
                p[n] = mk(OP_SUB, AD_K + i * 2 + k, 0, 0);           n++;
                p[n] = mk(OP_ST, 0, 0, AD_A + i * 2 + k);            n++;
            end
        end
        // T = (I - K H) P; the bias row adds P unchanged
        for (i = 0; i < 3; i++) begin
            for (j = 0; j < 3; j++) begin
                p[n] = mk(OP_CLR, 0, 0, 0);                          n++;
                p[n] = mk(OP_MADD, AD_A + i * 2, AD_P + j, 0);       n++;
                p[n] = mk(OP_MADD, AD_A + i * 2 + 1, AD_P + 3 + j, 0); n++;
                if (i == 2) begin
                    p[n] = mk(OP_ADD, AD_P + 6 + j, 0, 0);           n++;
                end
                p[n] = mk(OP_ST, 0, 0, AD_T + i * 3 + j);            n++;
            end
        end
        for (i = 0; i < 9; i++) begin
            p[n] = mk(OP_LD, AD_T + i, 0, 0); n++;
            p[n] = mk(OP_ST, 0, 0, AD_P + i); n++;
        end
        // update skipped on a singular S
        p[bz] = mk(OP_BZ, 0, 0, n);
        p[n] = mk(OP_OUT, AD_X + 0, AD_X + 1, 0); n++;
        // state prediction
        p[n] = mk(OP_LD, AD_X + 0, 0, 0);         n++;
        p[n] = mk(OP_MSUB, AD_TS, AD_X + 2, 0);   n++;
        p[n] = mk(OP_MADD, AD_TS, AD_U0, 0);      n++;
        p[n] = mk(OP_ST, 0, 0, AD_X + 0);         n++;
        p[n] = mk(OP_LD, AD_X + 1, 0, 0);         n++;
        p[n] = mk(OP_MADD, AD_GAIN, AD_U1, 0);    n++;
        p[n] = mk(OP_ST, 0, 0, AD_X + 1);         n++;
        // first row of phi P
        for (j = 0; j < 3; j++) begin
            p[n] = mk(OP_LD, AD_P + j, 0, 0);         n++;
            p[n] = mk(OP_MSUB, AD_TS, AD_P + 6 + j, 0); n++;
            p[n] = mk(OP_ST, 0, 0, AD_T + j);         n++;
        end
        // first row and column of (phi P) phi' plus Q
        p[n] = mk(OP_LD, AD_T + 0, 0, 0);         n++;
        p[n] = mk(OP_MSUB, AD_TS, AD_T + 2, 0);   n++;
        p[n] = mk(OP_ST, 0, 0, AD_P + 0);         n++;
        p[n] = mk(OP_LD, AD_P + 0, 0, 0);         n++;
        p[n] = mk(OP_ADD, AD_NA, 0, 0);           n++;
        p[n] = mk(OP_ST, 0, 0, AD_P + 0);         n++;
        p[n] = mk(OP_LD, AD_T + 1, 0, 0);         n++;
        p[n] = mk(OP_ST, 0, 0, AD_P + 1);         n++;
        p[n] = mk(OP_LD, AD_T + 2, 0, 0);         n++;
        p[n] = mk(OP_ADD, AD_NC, 0, 0);           n++;
        p[n] = mk(OP_ST, 0, 0, AD_P + 2);         n++;
        p[n] = mk(OP_LD, AD_P + 3, 0, 0);         n++;
        p[n] = mk(OP_MSUB, AD_TS, AD_P + 5, 0);   n++;
        p[n] = mk(OP_ST, 0, 0, AD_P + 3);         n++;
        p[n] = mk(OP_LD, AD_P + 4, 0, 0);         n++;
        p[n] = mk(OP_ADD, AD_NV, 0, 0);           n++;
        p[n] = mk(OP_ST, 0, 0, AD_P + 4);         n++;
        p[n] = mk(OP_LD, AD_P + 6, 0, 0);         n++;
        p[n] = mk(OP_MSUB, AD_TS, AD_P + 8, 0);   n++;
        p[n] = mk(OP_ST, 0, 0, AD_P + 6);         n++;
        p[n] = mk(OP_LD, AD_P + 6, 0, 0);         n++;
        p[n] = mk(OP_ADD, AD_NC, 0, 0);           n++;
        p[n] = mk(OP_ST, 0, 0, AD_P + 6);         n++;
        p[n] = mk(OP_LD, AD_P + 8, 0, 0);         n++;
        p[n] = mk(OP_ADD, AD_NB, 0, 0);           n++;
        p[n] = mk(OP_ST, 0, 0, AD_P + 8);         n++;
        p[n] = mk(OP_END, 0, 0, 0);
        return p;
    endfunction

    localparam t_prog PROG = build_prog();

endpackage

### rtl/kabf_if.sv
// Valid/ready channel interfaces for the filter's input and result transfers.
// Depends on nothing.
interface kabf_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] measured_angle;
    logic signed [31:0] measured_velocity;
    logic signed [31:0] control_first;
    logic signed [31:0] control_second;

    modport source (output valid, output measured_angle, output measured_velocity,
                    output control_first, output control_second, input ready);
    modport sink   (input valid, input measured_angle, input measured_velocity,
                    input control_first, input control_second, output ready);
endinterface

interface kabf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] angle_estimate;
    logic signed [31:0] velocity_estimate;

    modport source (output valid, output angle_estimate, output velocity_estimate,
                    input ready);
    modport sink   (input valid, input angle_estimate, input velocity_estimate,
                    output ready);
endinterface

### rtl/kabf_regs.sv
// APB register bank holding the filter's configuration.
// Depends on kabf_pkg.
module kabf_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kabf_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output kabf_pkg::t_cfg                o_cfg
);
    import kabf_pkg::*;

    t_cfg r_cfg;
    t_reg w_idx;
    logic w_wr;

    assign w_idx  = t_reg'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_period       <= 31'd1049;
            r_cfg.input_gain          <= '0;
            r_cfg.noise_angle         <= 31'd105;
            r_cfg.noise_cross         <= '0;
            r_cfg.noise_velocity      <= 31'd210;
            r_cfg.noise_bias          <= 31'd315;
            r_cfg.meas_noise_angle    <= 31'd629146;
            r_cfg.meas_noise_velocity <= 31'd209715;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_TS:   r_cfg.sample_period       <= pwdata[30:0];
                REG_GAIN: r_cfg.input_gain          <= pwdata;
                REG_NA:   r_cfg.noise_angle         <= pwdata[30:0];
                REG_NC:   r_cfg.noise_cross         <= pwdata;
                REG_NV:   r_cfg.noise_velocity      <= pwdata[30:0];
                REG_NB:   r_cfg.noise_bias          <= pwdata[30:0];
                REG_MNA:  r_cfg.meas_noise_angle    <= pwdata[30:0];
                REG_MNV:  r_cfg.meas_noise_velocity <= pwdata[30:0];
                default:  ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (w_idx)
            REG_TS:   prdata = {1'b0, r_cfg.sample_period};
            REG_GAIN: prdata = r_cfg.input_gain;
            REG_NA:   prdata = {1'b0, r_cfg.noise_angle};
            REG_NC:   prdata = r_cfg.noise_cross;
            REG_NV:   prdata = {1'b0, r_cfg.noise_velocity};
            REG_NB:   prdata = {1'b0, r_cfg.noise_bias};
            REG_MNA:  prdata = {1'b0, r_cfg.meas_noise_angle};
            REG_MNV:  prdata = {1'b0, r_cfg.meas_noise_velocity};
            default:  prdata = '0;
        endcase
    end
endmodule

### rtl/kabf_div.sv
// Serial restoring divider, one quotient bit a cycle, saturating result.
// Depends on kabf_pkg.
module kabf_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [kabf_pkg::NUM_W-1:0] i_num_mag,
    input  logic [kabf_pkg::ACC_W-1:0] i_den_mag,
    input  logic                       i_neg,
    output logic                       o_done,
    output kabf_pkg::t_data            o_quot
);
    import kabf_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [ACC_W-1:0] r_rem;
    logic [NUM_W-1:0] r_q;
    logic [ACC_W-1:0] r_den;
    logic             r_neg;
    logic [ACC_W:0]   w_rem_sh;
    logic [ACC_W:0]   w_trial;

    assign w_rem_sh = {r_rem, r_q[NUM_W-1]};
    assign w_trial  = w_rem_sh - {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift and subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num_mag;
            r_den <= i_den_mag;
            r_neg <= i_neg;
        end else if (r_busy) begin
            if (!w_trial[ACC_W]) begin
                r_rem <= w_trial[ACC_W-1:0];
            end else begin
                r_rem <= w_rem_sh[ACC_W-1:0];
            end
            r_q <= {r_q[NUM_W-2:0], ~w_trial[ACC_W]};
        end
    end

    // sign and saturation
    always_comb begin
        if (!r_neg) begin
            o_quot = (r_q > NUM_W'(32'h7fff_ffff)) ? t_data'(32'h7fff_ffff)
                                                   : t_data'(r_q[DATA_W-1:0]);
        end else begin
            o_quot = (r_q > NUM_W'(32'h8000_0000)) ? t_data'(32'h8000_0000)
                                                   : t_data'(-r_q[DATA_W-1:0]);
        end
    end

    assign o_done = r_done;
endmodule

### rtl/kabf_dp.sv
// Datapath: working memory, operand select, multiplier, accumulator,
// divider and result register. Depends on kabf_pkg and kabf_div.
module kabf_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kabf_pkg::t_cmd     i_cmd,
    output kabf_pkg::t_sts     o_sts,
    input  kabf_pkg::t_cfg     i_cfg,
    input  kabf_pkg::t_data    i_measured_angle,
    input  kabf_pkg::t_data    i_measured_velocity,
    input  kabf_pkg::t_data    i_control_first,
    input  kabf_pkg::t_data    i_control_second,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output kabf_pkg::t_data    o_angle_estimate,
    output kabf_pkg::t_data    o_velocity_estimate
);
    import kabf_pkg::*;

    t_data r_mem [MEM_DEPTH];
    t_data r_mem_a;
    t_data r_mem_b;
    t_data r_y0;
    t_data r_y1;
    t_data r_u0;
    t_data r_u1;
    t_acc  r_acc;
    t_acc  r_det;
    t_acc  r_prod;
    logic  r_out_valid;
    t_data r_ang;
    t_data r_vel;

    t_data      w_opa;
    t_data      w_opb;
    t_acc       w_rnd;
    t_acc       w_opa_x;
    logic       w_div_op;
    logic       w_div_start;
    logic       w_div_done;
    t_data      w_quot;
    logic       w_st_we;
    t_data      w_st_data;
    logic [DATA_W-1:0] w_mag_a;
    logic [NUM_W-1:0]  w_num_mag;
    logic [ACC_W-1:0]  w_den_mag;
    logic       w_qneg;
    t_op        w_op;

    assign w_op = i_cmd.uop.op;

    // operands outside the memory
    function automatic t_data ext_val(input logic [OPA_W-1:0] a, input t_cfg c,
                                      input t_data y0, input t_data y1,
                                      input t_data u0, input t_data u1);
        case (a)
            OPA_W'(AD_TS):   return t_data'({1'b0, c.sample_period});
            OPA_W'(AD_GAIN): return t_data'(c.input_gain);
            OPA_W'(AD_NA):   return t_data'({1'b0, c.noise_angle});
            OPA_W'(AD_NC):   return t_data'(c.noise_cross);
            OPA_W'(AD_NV):   return t_data'({1'b0, c.noise_velocity});
            OPA_W'(AD_NB):   return t_data'({1'b0, c.noise_bias});
            OPA_W'(AD_MNA):  return t_data'({1'b0, c.meas_noise_angle});
            OPA_W'(AD_MNV):  return t_data'({1'b0, c.meas_noise_velocity});
            OPA_W'(AD_Y0):   return y0;
            OPA_W'(AD_Y1):   return y1;
            OPA_W'(AD_U0):   return u0;
            OPA_W'(AD_U1):   return u1;
            OPA_W'(AD_ONE):  return ONE_Q;
            default:         return '0;
        endcase
    endfunction

    assign w_opa = i_cmd.uop.a[OPA_W-1] ?
                   ext_val(i_cmd.uop.a, i_cfg, r_y0, r_y1, r_u0, r_u1) : r_mem_a;
    assign w_opb = i_cmd.uop.b[OPA_W-1] ?
                   ext_val(i_cmd.uop.b, i_cfg, r_y0, r_y1, r_u0, r_u1) : r_mem_b;
    assign w_opa_x = {{(ACC_W-DATA_W){w_opa[DATA_W-1]}}, w_opa};
    assign w_rnd   = (r_prod + HALF_Q) >>> FRAC_BITS;

    // memory writes: reset sweep, then stores
    assign w_div_op  = (w_op == OP_DIV) || (w_op == OP_DIVN);
    assign w_st_we   = i_cmd.exe && ((w_op == OP_ST) || (w_div_op && w_div_done));
    assign w_st_data = (w_op == OP_ST) ? sat32(r_acc) : w_quot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_we) begin
            r_mem[i_cmd.init_addr] <= (i_cmd.init_addr == MEM_AW'(AD_P + 8)) ?
                                      BIAS_VAR_RST : '0;
        end else if (w_st_we) begin
            r_mem[i_cmd.uop.d[MEM_AW-1:0]] <= w_st_data;
        end
        if (i_cmd.rd) begin
            r_mem_a <= r_mem[i_cmd.uop.a[MEM_AW-1:0]];
            r_mem_b <= r_mem[i_cmd.uop.b[MEM_AW-1:0]];
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_y0 <= i_measured_angle;
            r_y1 <= i_measured_velocity;
            r_u0 <= i_control_first;
            r_u1 <= i_control_second;
        end
    end

    // multiplier stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= ACC_W'(w_opa * w_opb);
        end
    end

    // accumulator and determinant
    always_ff @(posedge i_clk) begin
        if (i_cmd.exe) begin
            case (w_op)
                OP_CLR:   r_acc <= '0;
                OP_LD:    r_acc <= w_opa_x;
                OP_ADD:   r_acc <= r_acc + w_opa_x;
                OP_SUB:   r_acc <= r_acc - w_opa_x;
                OP_MADD:  r_acc <= r_acc + w_rnd;
                OP_MSUB:  r_acc <= r_acc - w_rnd;
                OP_STDET: r_det <= r_acc;
                default:  ;
            endcase
        end
    end

    // divider operands: |s| * 2^FRAC over |det|
    assign w_mag_a     = w_opa[DATA_W-1] ? DATA_W'(-w_opa) : DATA_W'(w_opa);
    assign w_num_mag   = {w_mag_a, {FRAC_BITS{1'b0}}};
    assign w_den_mag   = r_det[ACC_W-1] ? ACC_W'(-r_det) : ACC_W'(r_det);
    assign w_qneg      = w_opa[DATA_W-1] ^ (w_op == OP_DIVN) ^ r_det[ACC_W-1];
    assign w_div_start = i_cmd.mul && w_div_op;

    kabf_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_num_mag (w_num_mag),
        .i_den_mag (w_den_mag),
        .i_neg     (w_qneg),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exe && (w_op == OP_OUT) && !r_out_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exe && (w_op == OP_OUT) && !r_out_valid) begin
            r_ang <= w_opa;
            r_vel <= w_opb;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_angle_estimate    = r_ang;
    assign o_velocity_estimate = r_vel;

    assign o_sts.det_zero = (r_det == '0);
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_out_valid;
endmodule

### rtl/kabf_ctrl.sv
// Sequencer: memory clear after reset, then steps the micro-program
// read / multiply / execute per operation. Depends on kabf_pkg.
module kabf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  kabf_pkg::t_sts i_sts,
    output kabf_pkg::t_cmd o_cmd
);
    import kabf_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [PC_W-1:0]   r_pc;
    logic [PC_W-1:0]   n_pc;
    logic [MEM_AW-1:0] r_init_cnt;
    t_uop              w_uop;
    logic              w_step_done;

    assign w_uop = PROG[r_pc];

    // an operation finishes once its unit or the result register allows
    always_comb begin
        case (w_uop.op)
            OP_DIV, OP_DIVN: w_step_done = i_sts.div_done;
            OP_OUT:          w_step_done = i_sts.out_free;
            default:         w_step_done = 1'b1;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        unique case (r_state)
            ST_INIT: begin
                if (r_init_cnt == MEM_AW'(MEM_DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_READ;
                    n_pc    = '0;
                end
            end
            ST_READ: n_state = ST_MUL;
            ST_MUL:  n_state = ST_EXEC;
            ST_EXEC: begin
                if (w_step_done) begin
                    if (w_uop.op == OP_END) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_READ;
                        n_pc    = ((w_uop.op == OP_BZ) && i_sts.det_zero) ?
                                  w_uop.d : r_pc + 1'b1;
                    end
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd           = '0;
        o_cmd.uop       = w_uop;
        o_cmd.init_addr = r_init_cnt;
        o_in_ready      = 1'b0;
        unique case (r_state)
            ST_INIT: o_cmd.init_we = 1'b1;
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_READ: o_cmd.rd  = 1'b1;
            ST_MUL:  o_cmd.mul = 1'b1;
            ST_EXEC: o_cmd.exe = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_pc       <= '0;
            r_init_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            if (r_state == ST_INIT) r_init_cnt <= r_init_cnt + 1'b1;
        end
    end
endmodule

### rtl/kalman_angle_bias_filter.sv
// Top level of the three-state angle/velocity/bias Kalman filter.
// Depends on kabf_pkg, kabf_if, kabf_regs, kabf_ctrl, kabf_dp, assert_macros.svh.
//
//  channel   dir  handshake       carries
//  i_in      in   valid/ready     measured_angle, measured_velocity,
//                                 control_first, control_second
//  o_out     out  valid/ready     angle_estimate, velocity_estimate
//  APB       in   psel/penable    eight configuration registers
//
// One step runs 176 micro-operations, each as read, multiply and execute,
// through the single multiplier and accumulator; each of the four serial
// divisions holds its execute state until the divider is done. A singular S
// skips the update and its divisions, so that step is shorter.
// After reset the working memory is cleared before the first input is taken.
// A result waits in its output register; the next item is taken meanwhile,
// and the step stalls at its result only if that is unread.
`include "assert_macros.svh"

module kalman_angle_bias_filter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    kabf_in_if.sink                      i_in,
    kabf_out_if.source                   o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kabf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import kabf_pkg::*;

    t_cfg  w_cfg;
    t_cmd  w_cmd;
    t_sts  w_sts;
    logic  w_in_ready;

    kabf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    kabf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    kabf_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_cfg               (w_cfg),
        .i_measured_angle    (i_in.measured_angle),
        .i_measured_velocity (i_in.measured_velocity),
        .i_control_first     (i_in.control_first),
        .i_control_second    (i_in.control_second),
        .o_out_valid         (o_out.valid),
        .i_out_ready         (o_out.ready),
        .o_angle_estimate    (o_out.angle_estimate),
        .o_velocity_estimate (o_out.velocity_estimate)
    );

    assign i_in.ready = w_in_ready;

    // checks
    `ASSERT_NEXT(a_in_starts_step, i_clk, i_rst_n, i_in.valid && i_in.ready, w_cmd.rd, "input transfer did not start a step")
    `ASSERT_ALWAYS(a_div_in_exec, i_clk, i_rst_n, !w_sts.div_done || w_cmd.exe, "divider finished outside an execute cycle")
    `ASSERT_ALWAYS(a_no_input_in_clear, i_clk, i_rst_n, !w_cmd.init_we || !i_in.ready, "input taken during memory clear")
endmodule

### sim/kabf_tb_if.sv
// Testbench-side note: the channel interfaces come from the RTL (kabf_if.sv).
// This file holds the configuration address map shared by the testbench.
// Depends on kabf_pkg.
package kabf_tb_pkg;
    import kabf_pkg::*;

    // byte address of a register in the configuration map
    function automatic logic [PADDR_W-1:0] reg_addr(input t_reg r);
        return PADDR_W'(int'(r) * 4);
    endfunction
endpackage

### sim/tb_kalman_angle_bias_filter.sv
// Self-checking testbench for the angle/velocity/bias Kalman filter.
// Drives input transfers and APB writes, predicts each step in a scoreboard.
// Depends on kabf_pkg, kabf_tb_pkg, kabf_if and the filter RTL.
module tb_kalman_angle_bias_filter;
    timeunit 1ns;
    timeprecision 1ps;
    import kabf_pkg::*;
    import kabf_tb_pkg::*;

    typedef struct {
        longint meas_ang;
        longint meas_vel;
        longint ctl_a;
        longint ctl_b;
    } t_item;

    typedef struct {
        longint ang;
        longint vel;
    } t_est;

    // Fixed-point filter model plus queue of pending estimates
    class kabf_scoreboard;
        longint ts, gain, na, nc, nv, nb, mna, mnv;
        longint xs[3];
        longint pc[9];
        t_est   pending[$];
        int     errors;

        function new();
            ts = 1049; gain = 0; na = 105; nc = 0; nv = 210; nb = 315;
            mna = 629146; mnv = 209715;
            foreach (xs[i]) xs[i] = 0;
            foreach (pc[i]) pc[i] = 0;
            pc[8] = longint'(BIAS_VAR_RST);
            errors = 0;
        endfunction

        function longint clip(input longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // rounded Q product, floor shift
        function longint qmul(input longint a, input longint b);
            longint p;
            p = a * b + (longint'(1) << (FRAC_BITS - 1));
            return p >>> FRAC_BITS;
        endfunction

        function void set_reg(input t_reg r, input logic [31:0] v);
            longint u31;
            u31 = longint'(v[30:0]);
            case (r)
                REG_TS:   ts = u31;
                REG_GAIN: gain = longint'(signed'(v));
                REG_NA:   na = u31;
                REG_NC:   nc = longint'(signed'(v));
                REG_NV:   nv = u31;
                REG_NB:   nb = u31;
                REG_MNA:  mna = u31;
                REG_MNV:  mnv = u31;
                default: ;
            endcase
        endfunction

        // note an accepted input and queue its estimate
        function void note_input(input t_item it);
            longint s00, s01, s10, s11, det, e0, e1;
            longint iv[4];
            longint kg[6];
            longint am[9];
            longint tm[9];
            longint acc;
            t_est   est;
            s00 = clip(pc[0] + mna);
            s01 = pc[1];
            s10 = pc[3];
            s11 = clip(pc[4] + mnv);
            det = qmul(s00, s11) - qmul(s01, s10);
            if (det != 0) begin
                iv[0] = clip((s11 * (longint'(1) << FRAC_BITS)) / det);
                iv[1] = clip((-s01 * (longint'(1) << FRAC_BITS)) / det);
                iv[2] = clip((-s10 * (longint'(1) << FRAC_BITS)) / det);
                iv[3] = clip((s00 * (longint'(1) << FRAC_BITS)) / det);
                for (int i = 0; i < 3; i++) begin
                    kg[i*2]   = clip(qmul(pc[i*3], iv[0]) + qmul(pc[i*3+1], iv[2]));
                    kg[i*2+1] = clip(qmul(pc[i*3], iv[1]) + qmul(pc[i*3+1], iv[3]));
                end
                e0 = clip(it.meas_ang - xs[0]);
                e1 = clip(it.meas_vel - xs[1]);
                for (int i = 0; i < 3; i++)
                    xs[i] = clip(xs[i] + qmul(kg[i*2], e0) + qmul(kg[i*2+1], e1));
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        am[i*3+j] = clip(((i == j) ? (longint'(1) << FRAC_BITS) : 0)
                                         - (j < 2 ? kg[i*2+j] : 0));
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++) begin
                        acc = 0;
                        for (int k = 0; k < 3; k++) acc += qmul(am[i*3+k], pc[k*3+j]);
                        tm[i*3+j] = clip(acc);
                    end
                pc = tm;
            end
            est.ang = xs[0];
            est.vel = xs[1];
            pending.push_back(est);
            // prediction
            xs[0] = clip(xs[0] - qmul(ts, xs[2]) + qmul(ts, it.ctl_a));
            xs[1] = clip(xs[1] + qmul(gain, it.ctl_b));
            for (int j = 0; j < 3; j++) begin
                tm[j]   = clip(pc[j] - qmul(ts, pc[6+j]));
                tm[3+j] = pc[3+j];
                tm[6+j] = pc[6+j];
            end
            for (int i = 0; i < 3; i++) begin
                pc[i*3]   = clip(tm[i*3] - qmul(ts, tm[i*3+2]));
                pc[i*3+1] = tm[i*3+1];
                pc[i*3+2] = tm[i*3+2];
            end
            pc[0] = clip(pc[0] + na);
            pc[2] = clip(pc[2] + nc);
            pc[6] = clip(pc[6] + nc);
            pc[4] = clip(pc[4] + nv);
            pc[8] = clip(pc[8] + nb);
        endfunction

        // compare a result transfer with the oldest estimate
        function void check_result(input logic signed [31:0] ang,
                                   input logic signed [31:0] vel);
            t_est e;
            if (pending.size() == 0) begin
                report("result with nothing pending", 0, 0);
                return;
            end
            e = pending.pop_front();
            if (longint'(ang) != e.ang) report("angle_estimate", e.ang, longint'(ang));
            if (longint'(vel) != e.vel) report("velocity_estimate", e.vel, longint'(vel));
        endfunction

        function void report(input string what, input longint want, input longint got);
            errors++;
            if (errors <= 40) $display("MISMATCH %s: want %0d got %0d at %0t", what, want, got,
                                       $realtime);
        endfunction
    endclass

    localparam int RST_CYCLES = 8;
    localparam int STALL_LIMIT = 20000;
    localparam int STEP_CYCLES = 800;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic out_stall_en;
    int idle_cycles;
    bit timed_out;

    kabf_in_if  in_ch();
    kabf_out_if out_ch();
    kabf_scoreboard sb;

    kalman_angle_bias_filter uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.measured_angle = '0; in_ch.measured_velocity = '0;
        in_ch.control_first = '0; in_ch.control_second = '0;
        out_ch.ready = 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // receiver: stalls at random while stalling is enabled, else always ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.angle_estimate, out_ch.velocity_estimate);
            out_ch.ready <= !out_stall_en || ($urandom_range(0, 9) < 6);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic apb_write(input t_reg r, input logic [31:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= reg_addr(r); pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.set_reg(r, v);
        // idle bus before the next transfer
        @(posedge i_clk);
    endtask

    // send one item; valid stays high if another follows in the burst
    task automatic send_item(input t_item it, input bit keep);
        in_ch.valid <= 1'b1;
        in_ch.measured_angle    <= it.meas_ang[31:0];
        in_ch.measured_velocity <= it.meas_vel[31:0];
        in_ch.control_first     <= it.ctl_a[31:0];
        in_ch.control_second    <= it.ctl_b[31:0];
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_input(it);
        if (!keep) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (STEP_CYCLES) @(posedge i_clk);
    endtask

    function automatic longint rnd32();
        return longint'(signed'($urandom));
    endfunction

    // mostly plausible sensor values with occasional full-range noise
    function automatic t_item rand_item();
        t_item it;
        if ($urandom_range(0, 9) < 8) begin
            it.meas_ang = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
            it.meas_vel = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            it.ctl_a    = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            it.ctl_b    = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        end else begin
            it.meas_ang = rnd32(); it.meas_vel = rnd32();
            it.ctl_a = rnd32(); it.ctl_b = rnd32();
        end
        return it;
    endfunction

    task automatic random_phase(input int count);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 6);
            if (burst > left) burst = left;
            for (int b = 0; b < burst; b++) send_item(rand_item(), b < burst - 1);
            left -= burst;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 900)) @(posedge i_clk);
        end
    endtask

    localparam longint MAXV = 64'sd2147483647;
    localparam longint MINV = -64'sd2147483648;

    initial begin
        t_item it;
        out_stall_en = 1'b1;
        @(posedge i_rst_n);
        @(posedge i_clk);

        // directed: extremes of every field
        it = '{0, 0, 0, 0};                 send_item(it, 0);
        it = '{MAXV, MAXV, MAXV, MAXV};     send_item(it, 0);
        it = '{MINV, MINV, MINV, MINV};     send_item(it, 0);
        it = '{MAXV, MINV, -1, 1};          send_item(it, 1);
        it = '{-1, -1, MINV, MAXV};         send_item(it, 0);
        drain();

        // large gain and cross noise, zero period
        apb_write(REG_GAIN, 32'h7fff_ffff);
        apb_write(REG_NC, 32'h8000_0000);
        apb_write(REG_TS, 32'h0000_0000);
        for (int i = 0; i < 5; i++) begin
            it = '{rnd32(), rnd32(), MAXV, MINV}; send_item(it, 0);
        end
        drain();

        // zero measurement and process noise, towards a singular S
        apb_write(REG_MNA, 32'h0);
        apb_write(REG_MNV, 32'h0);
        apb_write(REG_NA, 32'h0);
        apb_write(REG_NV, 32'h0);
        apb_write(REG_NB, 32'h0);
        apb_write(REG_NC, 32'h0);
        for (int i = 0; i < 4; i++) send_item(rand_item(), 0);
        drain();

        // top of range, upper bit above width dropped
        apb_write(REG_TS, 32'hffff_ffff);
        apb_write(REG_NA, 32'hffff_ffff);
        apb_write(REG_NV, 32'h7fff_ffff);
        apb_write(REG_NB, 32'h7fff_ffff);
        apb_write(REG_MNA, 32'h7fff_ffff);
        apb_write(REG_MNV, 32'hffff_ffff);
        for (int i = 0; i < 6; i++) send_item(rand_item(), 0);
        drain();

        // nominal settings, receiver stalling
        apb_write(REG_TS, 32'd1049);
        apb_write(REG_GAIN, 32'd52429);
        apb_write(REG_NA, 32'd105);
        apb_write(REG_NC, 32'hffff_ff00);
        apb_write(REG_NV, 32'd210);
        apb_write(REG_NB, 32'd315);
        apb_write(REG_MNA, 32'd629146);
        apb_write(REG_MNV, 32'd209715);
        random_phase(150);
        drain();

        // receiver always ready
        out_stall_en = 1'b0;
        apb_write(REG_TS, $urandom_range(1, 1 << 22));
        apb_write(REG_GAIN, $urandom);
        apb_write(REG_MNA, $urandom_range(1, 1 << 24));
        apb_write(REG_MNV, $urandom_range(1, 1 << 24));
        random_phase(150);
        drain();

        // random TS, NC, NA and NB, receiver stalling
        out_stall_en = 1'b1;
        apb_write(REG_TS, $urandom);
        apb_write(REG_NC, $urandom);
        apb_write(REG_NA, $urandom);
        apb_write(REG_NB, $urandom);
        random_phase(120);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl
rtl/kabf_pkg.sv
rtl/kabf_if.sv
rtl/kabf_regs.sv
rtl/kabf_div.sv
rtl/kabf_dp.sv
rtl/kabf_ctrl.sv
rtl/kalman_angle_bias_filter.sv
sim/kabf_tb_if.sv
sim/tb_kalman_angle_bias_filter.sv
